### rtl/nclip_pkg.sv
// Shared constants, register indexes and the screen saturation function.
`default_nettype none
package nclip_pkg;

    localparam int FOCAL_WIDTH   = 10;
    localparam int HORIZON_WIDTH = 10;
    localparam int CENTER_WIDTH  = 11;
    localparam int SCREEN_WIDTH  = 16;
    localparam int CFG_IDX_WIDTH = 3;

    // Quotient bits kept by each projection divider; anything larger saturates.
    localparam int PROJ_Q_BITS = 17;
    localparam int PROJ_SUM_W  = PROJ_Q_BITS + 2;

    localparam logic [FOCAL_WIDTH-1:0]   FOCAL_RESET   = 10'd256;
    localparam logic [HORIZON_WIDTH-1:0] HORIZON_RESET = 10'd120;
    localparam logic [CENTER_WIDTH-1:0]  CENTER_RESET  = 11'd160;
    localparam int CAM_HEIGHT_UNITS = 100;
    localparam int NEAR_UNITS       = 5;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FOCAL   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CAMERA  = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_HORIZON = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CENTER  = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_NEAR    = 3'd4;

    localparam logic signed [SCREEN_WIDTH-1:0] SCREEN_MAX = 16'sh7FFF;
    localparam logic signed [SCREEN_WIDTH-1:0] SCREEN_MIN = 16'sh8000;

    // Applies the sign to the quotient magnitude, adds the offset and clamps to 16 bits.
    function automatic logic [SCREEN_WIDTH-1:0] screen_coord(
        input logic                    neg,
        input logic                    big,
        input logic                    nonzero,
        input logic [PROJ_Q_BITS-1:0]  quot,
        input logic [CENTER_WIDTH-1:0] offset
    );
        logic signed [PROJ_SUM_W-1:0] q_s;
        logic signed [PROJ_SUM_W-1:0] sum;
        logic [SCREEN_WIDTH-1:0]      res;
        q_s = nonzero ? signed'({2'b00, quot}) : '0;
        if (neg) begin
            q_s = -q_s;
        end
        sum = q_s + signed'({{(PROJ_SUM_W-CENTER_WIDTH){1'b0}}, offset});
        if (big) begin
            res = neg ? SCREEN_MIN : SCREEN_MAX;
        end else if (sum > signed'({{(PROJ_SUM_W-SCREEN_WIDTH){1'b0}}, SCREEN_MAX})) begin
            res = SCREEN_MAX;
        end else if (sum < signed'({{(PROJ_SUM_W-SCREEN_WIDTH){1'b1}}, SCREEN_MIN})) begin
            res = SCREEN_MIN;
        end else begin
            res = sum[SCREEN_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/nclip_div_cell.sv
// One restoring-division cell: retires one quotient bit per lane and hands on.
`default_nettype none
module nclip_div_cell #(
    parameter int DIV_W = 25,
    parameter int LOW_W = 25,
    parameter int LANES = 2,
    parameter int PAY_W = 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [LANES-1:0][DIV_W-1:0]    in_rem,
    input  wire logic [LANES-1:0][LOW_W-1:0]    in_low,
    input  wire logic [LANES-1:0][LOW_W-1:0]    in_quot,
    input  wire logic [DIV_W-1:0]               in_div,
    input  wire logic [PAY_W-1:0]               in_pay,
    output logic                                out_valid,
    output logic      [LANES-1:0][DIV_W-1:0]    out_rem,
    output logic      [LANES-1:0][LOW_W-1:0]    out_low,
    output logic      [LANES-1:0][LOW_W-1:0]    out_quot,
    output logic      [DIV_W-1:0]               out_div,
    output logic      [PAY_W-1:0]               out_pay
);

    logic                         valid_reg;
    logic [LANES-1:0][DIV_W-1:0]  rem_reg,  rem_next;
    logic [LANES-1:0][LOW_W-1:0]  low_reg,  low_next;
    logic [LANES-1:0][LOW_W-1:0]  quot_reg, quot_next;
    logic [DIV_W-1:0]             div_reg;
    logic [PAY_W-1:0]             pay_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            logic [DIV_W:0] trial;
            logic [DIV_W:0] diff;
            logic           ge;
            trial = {in_rem[l], in_low[l][LOW_W-1]};
            diff  = trial - {1'b0, in_div};
            ge    = trial >= {1'b0, in_div};
            rem_next[l]  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            low_next[l]  = {in_low[l][LOW_W-2:0], 1'b0};
            quot_next[l] = {in_quot[l][LOW_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            quot_reg <= quot_next;
            div_reg  <= in_div;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_quot  = quot_reg;
    assign out_div   = div_reg;
    assign out_pay   = pay_reg;

endmodule
`default_nettype wire

### rtl/nclip_div_chain.sv
// Row of division cells, one quotient bit per cell, sharing one divisor across lanes.
`default_nettype none
module nclip_div_chain #(
    parameter int DIV_W = 25,
    parameter int STEPS = 25,
    parameter int LANES = 2,
    parameter int PAY_W = 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [LANES-1:0][DIV_W-1:0]    in_rem,
    input  wire logic [LANES-1:0][STEPS-1:0]    in_low,
    input  wire logic [DIV_W-1:0]               in_div,
    input  wire logic [PAY_W-1:0]               in_pay,
    output logic                                out_valid,
    output logic      [LANES-1:0][STEPS-1:0]    out_quot,
    output logic      [PAY_W-1:0]               out_pay
);

    logic                        valid_w [STEPS+1];
    logic [LANES-1:0][DIV_W-1:0] rem_w   [STEPS+1];
    logic [LANES-1:0][STEPS-1:0] low_w   [STEPS+1];
    logic [LANES-1:0][STEPS-1:0] quot_w  [STEPS+1];
    logic [DIV_W-1:0]            div_w   [STEPS+1];
    logic [PAY_W-1:0]            pay_w   [STEPS+1];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = in_rem;
    assign low_w[0]   = in_low;
    assign quot_w[0]  = '0;
    assign div_w[0]   = in_div;
    assign pay_w[0]   = in_pay;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        nclip_div_cell #(
            .DIV_W (DIV_W),
            .LOW_W (STEPS),
            .LANES (LANES),
            .PAY_W (PAY_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (valid_w[k]),
            .in_rem    (rem_w[k]),
            .in_low    (low_w[k]),
            .in_quot   (quot_w[k]),
            .in_div    (div_w[k]),
            .in_pay    (pay_w[k]),
            .out_valid (valid_w[k+1]),
            .out_rem   (rem_w[k+1]),
            .out_low   (low_w[k+1]),
            .out_quot  (quot_w[k+1]),
            .out_div   (div_w[k+1]),
            .out_pay   (pay_w[k+1])
        );
    end

    assign out_valid = valid_w[STEPS];
    assign out_quot  = quot_w[STEPS];
    assign out_pay   = pay_w[STEPS];

endmodule
`default_nettype wire

### rtl/near_clip_project_line_core.sv
// Top level: near-plane clipping and perspective projection of 3D line segments.
// The s_ channel carries one segment per transaction: start_x, start_y, start_z,
// end_x, end_y, end_z packed from the lowest bit of s_tdata, each COORD_WIDTH bits
// signed with FRAC_BITS fraction bits. The m_ channel returns one transaction per
// segment: the four saturated screen coordinates in m_tdata and the visible flag
// in m_tuser. A segment wholly nearer than the near plane returns visible low and
// zero coordinates.
// The configuration port writes focal length, camera height, horizon row, center
// column and near plane by index; the user must write it only while the block is
// idle, and the block itself does not enforce this. A new segment can be taken
// every cycle unless the output stalls. A segment passes the input and setup
// registers, the clipping divider row of COORD_WIDTH + 1 cells, the clip and scale
// registers, one projection divider row of 17 cells per endpoint and the output register.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register
// defaults. When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds its contents and s_tready drops until the result is taken.
`default_nettype none
module near_clip_project_line_core #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Fields from bit 0: start_x, start_y, start_z, end_x, end_y, end_z.
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: screen_x1, screen_y1, screen_x2, screen_y2.
    output logic [4*nclip_pkg::SCREEN_WIDTH-1:0]    m_tdata,
    // Field: visible.
    output logic [0:0]                              m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_we,
    input  wire logic [nclip_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]             cfg_wdata
);
    import nclip_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int W   = CW + 1;
    localparam int NW  = CW - 1;
    localparam int MW  = CW + 11;
    localparam int QB  = PROJ_Q_BITS;
    localparam int CLIP_PAY_W = 8 * CW + 5;
    localparam int PROJ_PAY_W = 7;

    // Configuration registers.
    logic [FOCAL_WIDTH-1:0]   focal_reg;
    logic signed [CW-1:0]     camera_reg;
    logic [HORIZON_WIDTH-1:0] horizon_reg;
    logic [CENTER_WIDTH-1:0]  center_reg;
    logic [NW-1:0]            near_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg   <= FOCAL_RESET;
            camera_reg  <= CW'(CAM_HEIGHT_UNITS << FRAC_BITS);
            horizon_reg <= HORIZON_RESET;
            center_reg  <= CENTER_RESET;
            near_reg    <= NW'(NEAR_UNITS << FRAC_BITS);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FOCAL:   focal_reg   <= cfg_wdata[FOCAL_WIDTH-1:0];
                CFG_CAMERA:  camera_reg  <= cfg_wdata;
                CFG_HORIZON: horizon_reg <= cfg_wdata[HORIZON_WIDTH-1:0];
                CFG_CENTER:  center_reg  <= cfg_wdata[CENTER_WIDTH-1:0];
                CFG_NEAR:    near_reg    <= cfg_wdata[NW-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a result is waiting on a stalled receiver.
    logic m_tvalid_reg;
    logic en;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Stage 0: input registers.
    logic                 v0_reg;
    logic signed [CW-1:0] x1_0_reg, y1_0_reg, z1_0_reg, x2_0_reg, y2_0_reg, z2_0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_0_reg <= s_tdata[0*CW +: CW];
            y1_0_reg <= s_tdata[1*CW +: CW];
            z1_0_reg <= s_tdata[2*CW +: CW];
            x2_0_reg <= s_tdata[3*CW +: CW];
            y2_0_reg <= s_tdata[4*CW +: CW];
            z2_0_reg <= s_tdata[5*CW +: CW];
        end
    end

    // Stage 1: near tests, pick the near endpoint, set up the clipping ratio.
    logic                 near1, near2;
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    logic [W-1:0]         num_c, den_c, dx_c, dy_c;

    assign near1 = signed'({z1_0_reg[CW-1], z1_0_reg}) < signed'({2'b00, near_reg});
    assign near2 = signed'({z2_0_reg[CW-1], z2_0_reg}) < signed'({2'b00, near_reg});
    assign ax = near1 ? x1_0_reg : x2_0_reg;
    assign ay = near1 ? y1_0_reg : y2_0_reg;
    assign az = near1 ? z1_0_reg : z2_0_reg;
    assign bx = near1 ? x2_0_reg : x1_0_reg;
    assign by = near1 ? y2_0_reg : y1_0_reg;
    assign bz = near1 ? z2_0_reg : z1_0_reg;
    assign num_c = {2'b00, near_reg} - {az[CW-1], az};
    assign den_c = {bz[CW-1], bz} - {az[CW-1], az};
    assign dx_c  = {bx[CW-1], bx} - {ax[CW-1], ax};
    assign dy_c  = {by[CW-1], by} - {ay[CW-1], ay};

    logic                 v1_reg, vis1_reg, clip1_1_reg, clip2_1_reg, sx1_reg, sy1_reg;
    logic signed [CW-1:0] x1_1_reg, y1_1_reg, z1_1_reg, x2_1_reg, y2_1_reg, z2_1_reg;
    logic signed [CW-1:0] ax1_reg, ay1_reg;
    logic [W-1:0]         num1_reg, den1_reg, magx1_reg, magy1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vis1_reg    <= !(near1 && near2);
            clip1_1_reg <= near1;
            clip2_1_reg <= !near1 && near2;
            x1_1_reg <= x1_0_reg; y1_1_reg <= y1_0_reg; z1_1_reg <= z1_0_reg;
            x2_1_reg <= x2_0_reg; y2_1_reg <= y2_0_reg; z2_1_reg <= z2_0_reg;
            ax1_reg  <= ax;
            ay1_reg  <= ay;
            sx1_reg  <= dx_c[W-1];
            sy1_reg  <= dy_c[W-1];
            magx1_reg <= dx_c[W-1] ? -dx_c : dx_c;
            magy1_reg <= dy_c[W-1] ? -dy_c : dy_c;
            num1_reg <= num_c;
            den1_reg <= den_c;
        end
    end

    // Stage 2: numerators of the clipping ratio for x and y.
    logic                   v2_reg;
    logic [2*W-1:0]         prodx2_reg, prody2_reg;
    logic [W-1:0]           den2_reg;
    logic [CLIP_PAY_W-1:0]  pay2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prodx2_reg <= {{W{1'b0}}, num1_reg} * {{W{1'b0}}, magx1_reg};
            prody2_reg <= {{W{1'b0}}, num1_reg} * {{W{1'b0}}, magy1_reg};
            den2_reg   <= den1_reg;
            pay2_reg   <= {vis1_reg, clip1_1_reg, clip2_1_reg, sx1_reg, sy1_reg,
                           ax1_reg, ay1_reg, x1_1_reg, y1_1_reg, z1_1_reg,
                           x2_1_reg, y2_1_reg, z2_1_reg};
        end
    end

    // Clipping division: step = num * |b - a| / (z_far - z_near), one bit per cell.
    logic                  vc_out;
    logic [1:0][W-1:0]     clip_quot;
    logic [CLIP_PAY_W-1:0] clip_pay;

    nclip_div_chain #(
        .DIV_W (W),
        .STEPS (W),
        .LANES (2),
        .PAY_W (CLIP_PAY_W)
    ) u_clip_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_rem    ({prody2_reg[2*W-1:W], prodx2_reg[2*W-1:W]}),
        .in_low    ({prody2_reg[W-1:0], prodx2_reg[W-1:0]}),
        .in_div    (den2_reg),
        .in_pay    (pay2_reg),
        .out_valid (vc_out),
        .out_quot  (clip_quot),
        .out_pay   (clip_pay)
    );

    // Stage 3: move the near endpoint onto the plane.
    logic                 c_vis, c_clip1, c_clip2, c_sx, c_sy;
    logic signed [CW-1:0] c_ax, c_ay, c_x1, c_y1, c_z1, c_x2, c_y2, c_z2;
    logic [W-1:0]         newx_w, newy_w;
    logic signed [CW-1:0] np_s;

    assign {c_vis, c_clip1, c_clip2, c_sx, c_sy, c_ax, c_ay,
            c_x1, c_y1, c_z1, c_x2, c_y2, c_z2} = clip_pay;
    assign newx_w = c_sx ? ({c_ax[CW-1], c_ax} - clip_quot[0])
                         : ({c_ax[CW-1], c_ax} + clip_quot[0]);
    assign newy_w = c_sy ? ({c_ay[CW-1], c_ay} - clip_quot[1])
                         : ({c_ay[CW-1], c_ay} + clip_quot[1]);
    assign np_s = {1'b0, near_reg};

    logic                 v3_reg, vis3_reg;
    logic signed [CW-1:0] x1_3_reg, y1_3_reg, z1_3_reg, x2_3_reg, y2_3_reg, z2_3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= vc_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vis3_reg <= c_vis;
            x1_3_reg <= c_clip1 ? newx_w[CW-1:0] : c_x1;
            y1_3_reg <= c_clip1 ? newy_w[CW-1:0] : c_y1;
            z1_3_reg <= c_clip1 ? np_s : c_z1;
            x2_3_reg <= c_clip2 ? newx_w[CW-1:0] : c_x2;
            y2_3_reg <= c_clip2 ? newy_w[CW-1:0] : c_y2;
            z2_3_reg <= c_clip2 ? np_s : c_z2;
        end
    end

    // Stage 4: subtract y from the camera height and scale by the focal length.
    logic signed [CW:0]          cy1, cy2;
    logic signed [FOCAL_WIDTH:0] focal_s;
    logic signed [MW-1:0]        px1_w, py1_w, px2_w, py2_w;

    assign cy1     = {camera_reg[CW-1], camera_reg} - {y1_3_reg[CW-1], y1_3_reg};
    assign cy2     = {camera_reg[CW-1], camera_reg} - {y2_3_reg[CW-1], y2_3_reg};
    assign focal_s = {1'b0, focal_reg};
    assign px1_w   = MW'(x1_3_reg) * MW'(focal_s);
    assign py1_w   = MW'(cy1) * MW'(focal_s);
    assign px2_w   = MW'(x2_3_reg) * MW'(focal_s);
    assign py2_w   = MW'(cy2) * MW'(focal_s);

    logic                 v4_reg, vis4_reg;
    logic signed [MW-1:0] px1_4_reg, py1_4_reg, px2_4_reg, py2_4_reg;
    logic [CW-1:0]        z1_4_reg, z2_4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vis4_reg  <= vis3_reg;
            px1_4_reg <= px1_w;
            py1_4_reg <= py1_w;
            px2_4_reg <= px2_w;
            py2_4_reg <= py2_w;
            z1_4_reg  <= z1_3_reg;
            z2_4_reg  <= z2_3_reg;
        end
    end

    // Stage 5: magnitudes, zero tests and the early saturation test per coordinate.
    // A quotient of 2^17 or more saturates whatever the offset, as does a zero depth under a nonzero product.
    logic [3:0][MW-1:0] mag_w;
    logic [3:0]         neg_w, nz_w, big_w;
    logic [3:0][CW-1:0] zz_w;

    assign zz_w = {z2_4_reg, z2_4_reg, z1_4_reg, z1_4_reg};

    always_comb begin
        logic signed [MW-1:0] p [4];
        p[0] = px1_4_reg;
        p[1] = py1_4_reg;
        p[2] = px2_4_reg;
        p[3] = py2_4_reg;
        for (int i = 0; i < 4; i++) begin
            neg_w[i] = p[i][MW-1];
            mag_w[i] = neg_w[i] ? MW'(-p[i]) : MW'(p[i]);
            nz_w[i]  = |p[i];
            big_w[i] = nz_w[i] && ((mag_w[i] >> QB) >= MW'(zz_w[i]));
        end
    end

    logic               v5_reg, vis5_reg;
    logic [3:0][CW-1:0] rem5_reg;
    logic [3:0][QB-1:0] low5_reg;
    logic [3:0]         neg5_reg, nz5_reg, big5_reg;
    logic [CW-1:0]      z1_5_reg, z2_5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vis5_reg <= vis4_reg;
            for (int i = 0; i < 4; i++) begin
                rem5_reg[i] <= CW'(mag_w[i] >> QB);
                low5_reg[i] <= mag_w[i][QB-1:0];
            end
            neg5_reg <= neg_w;
            nz5_reg  <= nz_w;
            big5_reg <= big_w;
            z1_5_reg <= z1_4_reg;
            z2_5_reg <= z2_4_reg;
        end
    end

    // Projection division, one row per endpoint with x and y sharing the depth.
    logic                  vp1_out, vp2_out;
    logic [1:0][QB-1:0]    quot1, quot2;
    logic [PROJ_PAY_W-1:0] ppay1, ppay2;

    nclip_div_chain #(
        .DIV_W (CW),
        .STEPS (QB),
        .LANES (2),
        .PAY_W (PROJ_PAY_W)
    ) u_proj_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_rem    ({rem5_reg[1], rem5_reg[0]}),
        .in_low    ({low5_reg[1], low5_reg[0]}),
        .in_div    (z1_5_reg),
        .in_pay    ({vis5_reg, neg5_reg[1:0], nz5_reg[1:0], big5_reg[1:0]}),
        .out_valid (vp1_out),
        .out_quot  (quot1),
        .out_pay   (ppay1)
    );

    nclip_div_chain #(
        .DIV_W (CW),
        .STEPS (QB),
        .LANES (2),
        .PAY_W (PROJ_PAY_W)
    ) u_proj_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_rem    ({rem5_reg[3], rem5_reg[2]}),
        .in_low    ({low5_reg[3], low5_reg[2]}),
        .in_div    (z2_5_reg),
        .in_pay    ({vis5_reg, neg5_reg[3:2], nz5_reg[3:2], big5_reg[3:2]}),
        .out_valid (vp2_out),
        .out_quot  (quot2),
        .out_pay   (ppay2)
    );

    // Output register: sign, offset and 16-bit clamp.
    logic                     f_vis;
    logic [1:0]               f_neg1, f_nz1, f_big1, f_neg2, f_nz2, f_big2;
    logic                     f_vis2;
    logic [SCREEN_WIDTH-1:0]  sx1_w, sy1_w, sx2_w, sy2_w;
    logic [CENTER_WIDTH-1:0]  horizon_ext;

    assign {f_vis, f_neg1, f_nz1, f_big1} = ppay1;
    assign {f_vis2, f_neg2, f_nz2, f_big2} = ppay2;
    assign horizon_ext = {1'b0, horizon_reg};

    assign sx1_w = screen_coord(f_neg1[0], f_big1[0], f_nz1[0], quot1[0], center_reg);
    assign sy1_w = screen_coord(f_neg1[1], f_big1[1], f_nz1[1], quot1[1], horizon_ext);
    assign sx2_w = screen_coord(f_neg2[0], f_big2[0], f_nz2[0], quot2[0], center_reg);
    assign sy2_w = screen_coord(f_neg2[1], f_big2[1], f_nz2[1], quot2[1], horizon_ext);

    logic [4*SCREEN_WIDTH-1:0] m_tdata_reg, m_tdata_next;
    logic                      m_tuser_reg;

    assign m_tdata_next = (f_vis && f_vis2) ? {sy2_w, sx2_w, sy1_w, sx1_w} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vp1_out && vp2_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= f_vis;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
`default_nettype wire
